// ===== design/sscu_pkg.sv =====
`timescale 1ns / 1ps

package sscu_pkg;

    // result classes, in order of priority
    typedef enum logic [2:0] {
        CLS_NONE    = 3'd0,
        CLS_AT      = 3'd1,
        CLS_KEYWORD = 3'd2,
        CLS_TEMP    = 3'd3,
        CLS_GETLOCK = 3'd4
    } match_class_t;

    typedef struct packed {
        logic [7:0] sql_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic         statement_stateful;
        match_class_t match_class;
        logic         session_dirty;
    } out_item_t;

    // keyword prefix table, each string right-justified in 16 bytes
    localparam int unsigned NUM_KW  = 9;
    localparam int unsigned POS_W   = 4;
    localparam logic [POS_W-1:0] POS_MAX = 4'd15;
    localparam int unsigned KW_STR_W = 128;

    localparam logic [KW_STR_W-1:0] KW_STR [0:NUM_KW-1] = '{
        KW_STR_W'("SET"), KW_STR_W'("USE"), KW_STR_W'("LOCK"),
        KW_STR_W'("UNLOCK"), KW_STR_W'("FLUSH"), KW_STR_W'("HANDLER"),
        KW_STR_W'("PREPARE"), KW_STR_W'("DEALLOCATE"), KW_STR_W'("XA")
    };
    localparam logic [POS_W-1:0] KW_LEN [0:NUM_KW-1] = '{
        4'd3, 4'd3, 4'd4, 4'd6, 4'd5, 4'd7, 4'd7, 4'd10, 4'd2
    };

    localparam logic [47:0] CREATE_STR = "CREATE";
    localparam logic [POS_W-1:0] CREATE_LEN = 4'd6;

    // substring patterns
    localparam int unsigned TEMP_LEN = 9;
    localparam logic [TEMP_LEN*8-1:0] TEMP_STR = "TEMPORARY";
    localparam int unsigned GETLOCK_LEN = 8;
    localparam logic [GETLOCK_LEN*8-1:0] GETLOCK_STR = "GET_LOCK";

    localparam int unsigned SCAN_STATE_W = 4;

endpackage

// ===== design/sscu_scan.sv =====
`timescale 1ns / 1ps

module sscu_scan #(
    parameter int unsigned PLEN = 9,
    parameter logic [PLEN*8-1:0] PAT = '0
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic       clear,
    input  logic [7:0] ch,
    output logic       hit
);
    import sscu_pkg::*;

    localparam int unsigned IW = $clog2(PLEN*8);

    logic [SCAN_STATE_W-1:0] st_reg;
    logic [SCAN_STATE_W-1:0] st_next;
    logic [SCAN_STATE_W-1:0] st_inc;
    logic [IW-1:0]           bit_ofs;
    logic [7:0]              exp_ch;
    logic [7:0]              first_ch;

    always_comb
    begin
        bit_ofs  = IW'((PLEN - 1 - int'(st_reg)) * 8);
        exp_ch   = PAT[bit_ofs +: 8];
        first_ch = PAT[PLEN*8-1 -: 8];
        st_inc   = st_reg + SCAN_STATE_W'(1);
        hit      = 1'b0;
        st_next  = st_reg;
        if (step)
        begin
            if (ch == exp_ch)
            begin
                if (st_inc == SCAN_STATE_W'(PLEN))
                begin
                    hit     = 1'b1;
                    st_next = '0;
                end
                else
                begin
                    st_next = st_inc;
                end
            end
            else
            begin
                st_next = (ch == first_ch) ? SCAN_STATE_W'(1) : '0;
            end
        end
        if (clear)
        begin
            st_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule

// ===== design/sql_session_state_classifier_unit.sv =====
`timescale 1ns / 1ps

// sql session state classifier: takes statement text one byte per request on
// the in channel (last_byte marks the end of a statement) and, for the last
// byte only, returns one result on the out channel with the match class and
// the sticky session-dirty flag. leading space, tab, lf and cr are skipped;
// letters are folded to upper case. rules, first hit wins: any '@', a keyword
// prefix (SET USE LOCK UNLOCK FLUSH HANDLER PREPARE DEALLOCATE XA), a CREATE
// prefix with TEMPORARY later on, GET_LOCK anywhere. a statement seen while
// pooling_enabled is low, or once the session is dirty, reports class 0.
// rate: one byte per clock while in_ready is high; every byte updates the match registers
// in the cycle it is accepted, and a last byte loads the result register, so
// a result is visible in the cycle after its last byte is taken. a result left
// waiting on out_ready holds off further input only while the result register
// is full. the cfg channel is always ready; write it between statements.
module sql_session_state_classifier_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sscu_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sscu_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);
    import sscu_pkg::*;

    // config
    logic pooling_reg;

    // per-statement state
    logic              lead_reg, lead_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [NUM_KW-1:0] kw_alive_reg, kw_alive_next;
    logic              kw_hit_reg, kw_hit_next;
    logic              create_alive_reg, create_alive_next;
    logic              at_reg, at_next;
    logic              temp_found_reg, temp_found_next;
    logic              getlock_found_reg, getlock_found_next;
    logic              skip_reg, skip_next;
    logic              dirty_reg, dirty_next;

    // result register
    logic              res_valid_reg;
    out_item_t         res_reg;

    logic              accept;
    logic              last;
    logic [7:0]        c;
    logic [7:0]        u;
    logic              is_ws;
    logic              examine;
    logic              temp_hit;
    logic              getlock_hit;
    match_class_t      cls;
    logic [POS_W-1:0]  kw_ofs;
    logic [2:0]        cr_ofs;

    assign cfg_ready = 1'b1;
    assign in_ready  = !res_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    assign c       = in_data.sql_byte;
    assign last    = in_data.last_byte;
    // fold a-z to A-Z only
    assign u       = (c >= 8'h61 && c <= 8'h7A) ? (c - 8'd32) : c;
    assign is_ws   = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D);
    assign examine = !(lead_reg && is_ws);

    // substring matchers, run over everything after the leading space
    sscu_scan #(
        .PLEN (TEMP_LEN),
        .PAT  (TEMP_STR)
    ) u_scan_temp (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (accept && examine),
        .clear (accept && last),
        .ch    (u),
        .hit   (temp_hit)
    );

    sscu_scan #(
        .PLEN (GETLOCK_LEN),
        .PAT  (GETLOCK_STR)
    ) u_scan_getlock (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (accept && examine),
        .clear (accept && last),
        .ch    (u),
        .hit   (getlock_hit)
    );

    // match state after this byte
    always_comb
    begin
        lead_next          = lead_reg;
        pos_next           = pos_reg;
        kw_alive_next      = kw_alive_reg;
        kw_hit_next        = kw_hit_reg;
        create_alive_next  = create_alive_reg;
        at_next            = at_reg;
        temp_found_next    = temp_found_reg || temp_hit;
        getlock_found_next = getlock_found_reg || getlock_hit;
        skip_next          = skip_reg || !pooling_reg || dirty_reg;
        kw_ofs             = '0;
        cr_ofs             = '0;

        if (examine)
        begin
            lead_next = 1'b0;
            if (c == 8'h40)
            begin
                at_next = 1'b1;
            end
            // keyword prefixes, each checked at the current position
            for (int i = 0; i < NUM_KW; i++)
            begin
                if (kw_alive_reg[i] && (pos_reg < KW_LEN[i]))
                begin
                    kw_ofs = KW_LEN[i] - 4'd1 - pos_reg;
                    if (u == KW_STR[i][{kw_ofs, 3'b000} +: 8])
                    begin
                        if (pos_reg + 4'd1 == KW_LEN[i])
                        begin
                            kw_hit_next = 1'b1;
                        end
                    end
                    else
                    begin
                        kw_alive_next[i] = 1'b0;
                    end
                end
            end
            if (create_alive_reg && (pos_reg < CREATE_LEN))
            begin
                cr_ofs = 3'(CREATE_LEN - 4'd1 - pos_reg);
                if (u != CREATE_STR[{cr_ofs, 3'b000} +: 8])
                begin
                    create_alive_next = 1'b0;
                end
            end
            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 4'd1;
            end
        end

        // result class, first rule wins
        cls = CLS_NONE;
        if (!skip_next)
        begin
            if (at_next)
            begin
                cls = CLS_AT;
            end
            else if (kw_hit_next)
            begin
                cls = CLS_KEYWORD;
            end
            else if (create_alive_next && (pos_next >= CREATE_LEN) && temp_found_next)
            begin
                cls = CLS_TEMP;
            end
            else if (getlock_found_next)
            begin
                cls = CLS_GETLOCK;
            end
        end
        dirty_next = dirty_reg || (cls != CLS_NONE);
    end

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pooling_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pooling_reg <= cfg_data;
        end
    end

    // statement state; a last byte returns everything but the dirty flag to reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg          <= 1'b1;
            pos_reg           <= '0;
            kw_alive_reg      <= '1;
            kw_hit_reg        <= 1'b0;
            create_alive_reg  <= 1'b1;
            at_reg            <= 1'b0;
            temp_found_reg    <= 1'b0;
            getlock_found_reg <= 1'b0;
            skip_reg          <= 1'b0;
            dirty_reg         <= 1'b0;
        end
        else if (accept)
        begin
            if (last)
            begin
                lead_reg          <= 1'b1;
                pos_reg           <= '0;
                kw_alive_reg      <= '1;
                kw_hit_reg        <= 1'b0;
                create_alive_reg  <= 1'b1;
                at_reg            <= 1'b0;
                temp_found_reg    <= 1'b0;
                getlock_found_reg <= 1'b0;
                skip_reg          <= 1'b0;
                dirty_reg         <= dirty_next;
            end
            else
            begin
                lead_reg          <= lead_next;
                pos_reg           <= pos_next;
                kw_alive_reg      <= kw_alive_next;
                kw_hit_reg        <= kw_hit_next;
                create_alive_reg  <= create_alive_next;
                at_reg            <= at_next;
                temp_found_reg    <= temp_found_next;
                getlock_found_reg <= getlock_found_next;
                skip_reg          <= skip_next;
            end
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept && last)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept && last)
        begin
            res_reg.statement_stateful <= (cls != CLS_NONE);
            res_reg.match_class        <= cls;
            res_reg.session_dirty      <= dirty_next;
        end
    end

    // a last-byte request always produces a result in the next cycle
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> out_valid)
        else $error("last byte did not load a result");

    // stateful flag agrees with the class
    a_stateful_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.statement_stateful == (out_data.match_class != CLS_NONE)))
        else $error("stateful flag disagrees with match class");

    // a stateful statement leaves the session dirty
    a_stateful_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.statement_stateful |-> out_data.session_dirty)
        else $error("stateful result without dirty session");

    // dirty is sticky until reset
    a_dirty_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        dirty_reg |=> dirty_reg)
        else $error("session dirty flag cleared");

    // nothing examined while still in leading space
    a_lead_clean: assert property (@(posedge clk) disable iff (!rst_n)
        lead_reg |-> (pos_reg == '0) && (kw_alive_reg == '1) && !at_reg)
        else $error("match state moved during leading space");

endmodule
